// File: src/tpwg_pkg.sv
`timescale 1ns / 1ps

package tpwg_pkg;

	// Tuner type codes held in the configuration register
	typedef enum logic [1:0] {
		KIND_FOUR  = 2'd0,
		KIND_THREE = 2'd1,
		KIND_EIGHT = 2'd2
	} tuner_kind_t;

	localparam int FREQ_W = 30;
	localparam int SUM_W  = FREQ_W + 1;
	localparam int QUO_W  = 14;

	// Divider = (freq + DIV_OFFSET) / DIV_STEP
	localparam logic [SUM_W-1:0] DIV_OFFSET = 31'd36166667;
	localparam int unsigned      DIV_STEP   = 166667;

	// Reciprocal ceil(2^49 / 166667); its error term 143010 keeps the
	// quotient exact for every sum below 2^31.
	localparam int          RECIP_SHIFT = 49;
	localparam logic [31:0] RECIP       = 32'd3377692966;

	localparam logic [7:0] CTRL_BASE  = 8'h85;
	localparam logic [7:0] CTRL_EIGHT = 8'h93;

	typedef struct packed {
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] hi;
		logic [7:0]        code;
	} band_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} band_hit_t;

	localparam band_t BANDS_FOUR [4] = '{
		'{30'd47000000,  30'd153000000, 8'h01},
		'{30'd153000000, 30'd430000000, 8'h02},
		'{30'd430000000, 30'd824000000, 8'h0C},
		'{30'd824000000, 30'd863000000, 8'h8C}
	};

	localparam band_t BANDS_THREE [3] = '{
		'{30'd174000000, 30'd230000000, 8'h82},
		'{30'd470000000, 30'd782000000, 8'h85},
		'{30'd782000000, 30'd863000000, 8'hC5}
	};

	localparam band_t BANDS_EIGHT [8] = '{
		'{30'd51000000,  30'd132100000, 8'h05},
		'{30'd132100000, 30'd143000000, 8'h45},
		'{30'd146000000, 30'd349100000, 8'h06},
		'{30'd349100000, 30'd397100000, 8'h46},
		'{30'd397100000, 30'd426000000, 8'h86},
		'{30'd430000000, 30'd659100000, 8'h03},
		'{30'd659100000, 30'd759100000, 8'h43},
		'{30'd759100000, 30'd858000000, 8'h83}
	};

	// Find the half-open range [lo, hi) that holds f; first match wins
	function automatic band_hit_t find_band(input logic [FREQ_W-1:0] f, input tuner_kind_t kind);
		band_hit_t r;
		r = '0;
		unique case (kind)
			KIND_FOUR: begin
				for (int i = 3; i >= 0; i--)
					if (f >= BANDS_FOUR[i].lo && f < BANDS_FOUR[i].hi)
						r = '{hit: 1'b1, code: BANDS_FOUR[i].code};
			end
			KIND_THREE: begin
				for (int i = 2; i >= 0; i--)
					if (f >= BANDS_THREE[i].lo && f < BANDS_THREE[i].hi)
						r = '{hit: 1'b1, code: BANDS_THREE[i].code};
			end
			KIND_EIGHT: begin
				for (int i = 7; i >= 0; i--)
					if (f >= BANDS_EIGHT[i].lo && f < BANDS_EIGHT[i].hi)
						r = '{hit: 1'b1, code: BANDS_EIGHT[i].code};
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: src/tuner_pll_word_generator.sv
// Tuner PLL control-word generator.
// Two register stages: the input stage and the result register; a stalled output holds both.
// Throughput: one request per cycle while the output is not stalled; the divider is one
// reciprocal multiply and the band search is a parallel compare, both between the two registers.
// Reset: asynchronous, active low; clears valid flags and sets tuner_kind to 0.
`timescale 1ns / 1ps

module tuner_pll_word_generator import tpwg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FREQ_W-1:0] freq_hz,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        divider_high,
	output logic [7:0]        divider_low,
	output logic [7:0]        control_byte,
	output logic [7:0]        band_byte,
	output logic              out_of_band
);

	tuner_kind_t       kind_q;
	logic              valid_s1;
	logic [FREQ_W-1:0] freq_s1;
	logic              out_valid_q;
	logic [6:0]        div_high_q;
	logic [7:0]        div_low_q;
	logic [7:0]        ctrl_q;
	logic [7:0]        band_q;
	logic              oob_q;

	logic              adv;
	logic [SUM_W-1:0]  sum;
	logic [62:0]       prod;
	logic [QUO_W-1:0]  quo;
	logic [16:0]       div_w;
	band_hit_t         lk;
	logic [7:0]        ctrl;

	// Advance the whole pipe unless a result waits on a stalled output
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// Divider by reciprocal multiply
	assign sum   = {1'b0, freq_s1} + DIV_OFFSET;
	assign prod  = sum * RECIP;
	assign quo   = prod[RECIP_SHIFT +: QUO_W];
	assign div_w = {{(17-QUO_W){1'b0}}, quo};

	// Band search and control byte for the selected tuner type
	always_comb begin
		lk = find_band(freq_s1, kind_q);
		unique case (kind_q)
			KIND_THREE: ctrl = CTRL_BASE | {1'b0, div_w[16:15], 5'b0};
			KIND_EIGHT: ctrl = CTRL_EIGHT;
			default:    ctrl = CTRL_BASE;
		endcase
	end

	// Hold control state: config register and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_FOUR;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				kind_q <= tuner_kind_t'(cfg_wr_data);
			if (adv) begin
				valid_s1    <= in_valid;
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture request and result payloads; zero the bytes when out of band
	always_ff @(posedge clk) begin
		if (adv) begin
			freq_s1 <= freq_hz;
			if (lk.hit) begin
				div_high_q <= div_w[14:8];
				div_low_q  <= div_w[7:0];
				ctrl_q     <= ctrl;
				band_q     <= lk.code;
				oob_q      <= 1'b0;
			end else begin
				div_high_q <= '0;
				div_low_q  <= '0;
				ctrl_q     <= '0;
				band_q     <= '0;
				oob_q      <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign divider_high = div_high_q;
	assign divider_low  = div_low_q;
	assign control_byte = ctrl_q;
	assign band_byte    = band_q;
	assign out_of_band  = oob_q;

`ifndef SYNTHESIS
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_band |-> (divider_high == 7'd0 && divider_low == 8'd0
			&& control_byte == 8'd0 && band_byte == 8'd0))
		else $error("out-of-band result carries nonzero bytes");

	a_req_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request missing from input stage");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_stall |=> out_valid)
		else $error("input stage request lost before result register");
`endif

endmodule

// File: tb/tb_tuner_pll_word_generator.sv
`timescale 1ns / 1ps

module tb_tuner_pll_word_generator;
	import tpwg_pkg::*;

	localparam int          HALF_PERIOD   = 6;
	localparam int          RESET_CYCLES  = 10;
	localparam int          IDLE_PCT      = 20;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          FLUSH_CYCLES  = 8;
	localparam int          STUCK_LIMIT   = 2000;
	localparam int          CALM_FROM     = 420;
	localparam int          CALM_TO       = 560;

	localparam int unsigned DIVIDER_BIAS    = 36166667;
	localparam int unsigned DIVIDER_STEP_HZ = 166667;
	localparam logic [7:0]  CTRL_DEFAULT    = 8'h85;
	localparam logic [7:0]  CTRL_EIGHT_BAND = 8'h93;
	localparam logic [1:0]  KIND_UNUSED     = 2'd3;

	// Band edges of all three tables, used to aim random requests at limits
	localparam int NUM_EDGES = 19;
	localparam int unsigned BAND_EDGES [NUM_EDGES] = '{
		47000000, 153000000, 430000000, 824000000, 863000000,
		174000000, 230000000, 470000000, 782000000,
		51000000, 132100000, 143000000, 146000000, 349100000,
		397100000, 426000000, 659100000, 759100000, 858000000
	};

	// Directed requests: field extremes, band edges, table gaps, bit patterns
	localparam int NUM_SPOTS = 25;
	localparam logic [FREQ_W-1:0] SPOT_FREQS [NUM_SPOTS] = '{
		30'd0, 30'h3FFFFFFF, 30'd46999999, 30'd47000000, 30'd152999999,
		30'd153000000, 30'd429999999, 30'd430000000, 30'd823999999, 30'd824000000,
		30'd862999999, 30'd863000000, 30'd173999999, 30'd174000000, 30'd229999999,
		30'd469999999, 30'd782000000, 30'd50999999, 30'd132100000, 30'd142999999,
		30'd143000000, 30'd145999999, 30'd857999999, 30'h2AAAAAAA, 30'h15555555
	};

	localparam int NUM_PHASES = 6;
	localparam logic [1:0] PHASE_KIND [NUM_PHASES] = '{
		KIND_THREE, KIND_EIGHT, KIND_UNUSED, KIND_FOUR, KIND_EIGHT, KIND_THREE
	};
	localparam int PHASE_LEN [NUM_PHASES] = '{180, 180, 40, 180, 120, 120};

	typedef enum logic [1:0] {
		STEP_TUNE,
		STEP_SET_KIND,
		STEP_DRAIN
	} step_op_t;

	typedef struct packed {
		step_op_t          op;
		logic [FREQ_W-1:0] freq;
		logic [1:0]        kind;
	} tune_step_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [6:0]        div_hi;
		logic [7:0]        div_lo;
		logic [7:0]        ctrl;
		logic [7:0]        band;
		logic              oob;
	} pll_word_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [1:0]        cfg_wr_data = 2'd0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [FREQ_W-1:0] freq_hz     = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [6:0]        divider_high;
	logic [7:0]        divider_low;
	logic [7:0]        control_byte;
	logic [7:0]        band_byte;
	logic              out_of_band;

	tune_step_t tune_queue [$];
	pll_word_t  words_due [$];
	logic [1:0] kind_now      = KIND_FOUR;
	int         requests_sent = 0;
	int         sent_seen     = 0;
	int         settle_wait   = 0;
	int         mismatches    = 0;
	int         stuck_cycles  = 0;

	tuner_pll_word_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.freq_hz      (freq_hz),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.divider_high (divider_high),
		.divider_low  (divider_low),
		.control_byte (control_byte),
		.band_byte    (band_byte),
		.out_of_band  (out_of_band)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic in_span(input int unsigned f, input int unsigned lo,
			input int unsigned hi);
		return f >= lo && f < hi;
	endfunction

	// Compute the four control bytes and the band flag for one frequency
	function automatic pll_word_t pll_word_for(input logic [FREQ_W-1:0] f,
			input logic [1:0] kind);
		pll_word_t   w;
		int unsigned fu;
		logic [31:0] div;
		logic [7:0]  ctrl;
		logic [7:0]  code;
		logic        hit;
		fu   = 32'(f);
		div  = (fu + DIVIDER_BIAS) / DIVIDER_STEP_HZ;
		hit  = 1'b1;
		code = 8'h00;
		ctrl = 8'h00;
		case (kind)
			KIND_FOUR: begin
				ctrl = CTRL_DEFAULT;
				if (in_span(fu, 47000000, 153000000)) code = 8'h01;
				else if (in_span(fu, 153000000, 430000000)) code = 8'h02;
				else if (in_span(fu, 430000000, 824000000)) code = 8'h0C;
				else if (in_span(fu, 824000000, 863000000)) code = 8'h8C;
				else hit = 1'b0;
			end
			KIND_THREE: begin
				ctrl = CTRL_DEFAULT | {1'b0, div[16:15], 5'b0};
				if (in_span(fu, 174000000, 230000000)) code = 8'h82;
				else if (in_span(fu, 470000000, 782000000)) code = 8'h85;
				else if (in_span(fu, 782000000, 863000000)) code = 8'hC5;
				else hit = 1'b0;
			end
			KIND_EIGHT: begin
				ctrl = CTRL_EIGHT_BAND;
				if (in_span(fu, 51000000, 132100000)) code = 8'h05;
				else if (in_span(fu, 132100000, 143000000)) code = 8'h45;
				else if (in_span(fu, 146000000, 349100000)) code = 8'h06;
				else if (in_span(fu, 349100000, 397100000)) code = 8'h46;
				else if (in_span(fu, 397100000, 426000000)) code = 8'h86;
				else if (in_span(fu, 430000000, 659100000)) code = 8'h03;
				else if (in_span(fu, 659100000, 759100000)) code = 8'h43;
				else if (in_span(fu, 759100000, 858000000)) code = 8'h83;
				else hit = 1'b0;
			end
			default: hit = 1'b0;
		endcase
		w      = '0;
		w.freq = f;
		if (hit) begin
			w.div_hi = div[14:8];
			w.div_lo = div[7:0];
			w.ctrl   = ctrl;
			w.band   = code;
		end else begin
			w.oob = 1'b1;
		end
		return w;
	endfunction

	// Aim most requests at the tuning range and its band edges
	function automatic logic [FREQ_W-1:0] random_freq();
		int unsigned roll;
		int unsigned edge_hz;
		roll = $urandom_range(99);
		if (roll < 45)
			return FREQ_W'($urandom_range(900000000, 30000000));
		if (roll < 75) begin
			edge_hz = BAND_EDGES[$urandom_range(NUM_EDGES - 1)];
			return FREQ_W'(edge_hz + $urandom_range(6) - 3);
		end
		if (roll < 92)
			return FREQ_W'($urandom);
		if (roll < 96)
			return FREQ_W'($urandom_range(255));
		return 30'h3FFFFFFF - FREQ_W'($urandom_range(255));
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [FREQ_W-1:0] f,
			input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			note_mismatch($sformatf("freq %0d %s: got %h, want %h", f, name, got, want));
	endtask

	task automatic queue_tune(input logic [FREQ_W-1:0] f);
		tune_queue.push_back('{op: STEP_TUNE, freq: f, kind: 2'd0});
	endtask

	task automatic queue_kind(input logic [1:0] k);
		tune_queue.push_back('{op: STEP_SET_KIND, freq: '0, kind: k});
	endtask

	// Drive requests, tuner type writes and output stalls on the falling edge
	always @(negedge clk) begin
		tune_step_t        head;
		logic              send;
		logic [FREQ_W-1:0] next_freq;
		logic              wr_en;
		logic [1:0]        wr_data;
		logic              calm;
		if (arst_n) begin
			calm      = requests_sent >= CALM_FROM && requests_sent < CALM_TO;
			send      = in_valid && requests_sent == sent_seen;
			sent_seen = requests_sent;
			next_freq = freq_hz;
			wr_en     = 1'b0;
			wr_data   = cfg_wr_data;
			if (!send && tune_queue.size() > 0) begin
				head = tune_queue[0];
				case (head.op)
					STEP_TUNE: begin
						if (calm || $urandom_range(99) >= IDLE_PCT) begin
							send      = 1'b1;
							next_freq = head.freq;
							head      = tune_queue.pop_front();
						end
					end
					// Write the type only once the block has gone quiet
					STEP_SET_KIND: begin
						if (words_due.size() != 0) begin
							settle_wait = 0;
						end else if (settle_wait < SETTLE_CYCLES) begin
							settle_wait++;
						end else begin
							wr_en       = 1'b1;
							wr_data     = head.kind;
							settle_wait = 0;
							head        = tune_queue.pop_front();
						end
					end
					default: begin
						if (words_due.size() == 0)
							head = tune_queue.pop_front();
					end
				endcase
			end
			in_valid    <= send;
			freq_hz     <= next_freq;
			cfg_wr_en   <= wr_en;
			cfg_wr_data <= wr_data;
			out_stall   <= !calm && $urandom_range(99) < IDLE_PCT;
		end
	end

	// Check results and record accepted requests on the rising edge
	always @(posedge clk) begin
		pll_word_t want;
		if (arst_n) begin
			// compare against the oldest outstanding word
			if (out_valid && !out_stall) begin
				if (words_due.size() == 0) begin
					note_mismatch("result with no request outstanding");
				end else begin
					want = words_due.pop_front();
					check_field("divider_high", want.freq, {1'b0, divider_high},
						{1'b0, want.div_hi});
					check_field("divider_low", want.freq, divider_low, want.div_lo);
					check_field("control_byte", want.freq, control_byte, want.ctrl);
					check_field("band_byte", want.freq, band_byte, want.band);
					check_field("out_of_band", want.freq, {7'b0, out_of_band},
						{7'b0, want.oob});
				end
			end
			// predict each accepted request with the type in force
			if (in_valid && !in_stall) begin
				words_due.push_back(pll_word_for(freq_hz, kind_now));
				requests_sent++;
			end
			if (cfg_wr_en)
				kind_now = cfg_wr_data;
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SPOTS; i++)
			queue_tune(SPOT_FREQS[i]);
		for (int p = 0; p < NUM_PHASES; p++) begin
			queue_kind(PHASE_KIND[p]);
			for (int i = 0; i < PHASE_LEN[p]; i++) begin
				// hold off mid-phase until every word has come back
				if (p == 1 && i == PHASE_LEN[p] / 2)
					tune_queue.push_back('{op: STEP_DRAIN, freq: '0, kind: 2'd0});
				queue_tune(random_freq());
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (tune_queue.size() != 0 || in_valid || words_due.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
